/* hw/rtl/ffr_pkg.sv */
// Package for the fixed FIR reverb filter: sizes, coefficient ROM,
// sequencer states and the control struct of the MAC unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffr_pkg;

  localparam int TAP_COUNT   = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = 16;
  localparam int COEF_BITS   = 16;
  localparam int FRAC_BITS   = 15;
  localparam int ROM_LEN     = 64;
  localparam int HIST_LEN    = TAP_COUNT - 1;

  localparam int TAP_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int ROM_W = $clog2(ROM_LEN);
  localparam int IDX_W = (TAP_W > ROM_W) ? TAP_W : ROM_W;
  localparam int ACC_W = SAMPLE_BITS + COEF_BITS + TAP_W;
  localparam int Q_W   = ACC_W + 1 - FRAC_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_DONE
  } ffr_state_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
  } ffr_mac_ctrl_t;

  localparam coef_t COEF_ROM [ROM_LEN] = '{
    16'sd510,   -16'sd1313, 16'sd12677, 16'sd1517,  -16'sd1423, -16'sd155,  -16'sd717,  -16'sd488,
    -16'sd522,  -16'sd507,  -16'sd494,  -16'sd481,  -16'sd468,  -16'sd456,  -16'sd443,  -16'sd430,
    -16'sd418,  -16'sd406,  -16'sd393,  -16'sd381,  -16'sd370,  -16'sd358,  -16'sd346,  -16'sd336,
    -16'sd324,  -16'sd313,  -16'sd317,  -16'sd206,  -16'sd533,  16'sd325,   -16'sd1705, 16'sd8528,
    16'sd2011,  -16'sd1577, -16'sd421,  -16'sd208,  -16'sd1983, 16'sd7315,  16'sd1908,  -16'sd1977,
    -16'sd421,  -16'sd1081, -16'sd794,  -16'sd830,  -16'sd801,  -16'sd776,  -16'sd751,  -16'sd726,
    -16'sd703,  -16'sd679,  -16'sd655,  -16'sd632,  -16'sd609,  -16'sd587,  -16'sd566,  -16'sd544,
    -16'sd523,  -16'sd503,  -16'sd482,  -16'sd463,  -16'sd454,  -16'sd358,  -16'sd608,  16'sd87
  };

  // taps past the end of the ROM weigh zero
  function automatic coef_t tap_coef(input logic [IDX_W-1:0] idx);
    coef_t c;
    if ({1'b0, idx} < (IDX_W+1)'(ROM_LEN)) begin
      c = COEF_ROM[idx[ROM_W-1:0]];
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ffr_stream_if.sv */
// Valid/ready channel interfaces for the input and result samples.
// Depends on ffr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ffr_in_if import ffr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface ffr_out_if import ffr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ffr_mac.sv */
// Shared multiply-accumulate unit with rounding and saturation.
// Depends on ffr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffr_mac import ffr_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ffr_mac_ctrl_t              ctrl,
  input  wire coef_t                      coef,
  input  wire sample_t                    operand,
  output logic signed [OUT_BITS-1:0]      result
);

  localparam logic signed [Q_W-1:0] Q_MAX =
    Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

  logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_r;
  logic                                    prod_v_r;
  logic signed [ACC_W-1:0]                 acc_r;
  logic signed [ACC_W:0]                   rnd;
  logic signed [Q_W-1:0]                   q;
  logic signed [Q_W-1:0]                   sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctrl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= coef * operand;
    end
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, floor, clamp
  always_comb begin
    rnd = (ACC_W+1)'(acc_r) + ((ACC_W+1)'(1) <<< (FRAC_BITS - 1));
    q   = Q_W'(rnd >>> FRAC_BITS);
    if (q > Q_MAX) begin
      sat = Q_MAX;
    end else if (q < Q_MIN) begin
      sat = Q_MIN;
    end else begin
      sat = q;
    end
    result = OUT_BITS'(sat);
  end

endmodule
`default_nettype wire

/* hw/rtl/fixed_fir_reverb_filter_core.sv */
// Channel   Dir  Payload            Transfer
// in_ch     in   sample_in  s16     valid & ready
// out_ch    out  sample_out s16     valid & ready
//
// Each sample goes one tap per cycle through the shared MAC while the
// history shift line rotates past it, then drain and round. A finished
// result waits in the output register; the next sample is taken while it
// waits. Reset clears the history and the handshake state.
// Depends on ffr_pkg, ffr_stream_if, ffr_mac.
`timescale 1ns / 1ps
`default_nettype none
module fixed_fir_reverb_filter_core import ffr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ffr_in_if.sink     in_ch,
  ffr_out_if.source  out_ch
);

  ffr_state_t                 state_r, state_nxt;
  logic [TAP_W-1:0]           tap_r;
  sample_t                    x_r;
  sample_t                    hist_r [HIST_LEN];
  logic                       out_valid_r;
  logic signed [OUT_BITS-1:0] out_data_r;
  logic                       in_rdy;
  logic                       load_out;
  ffr_mac_ctrl_t              ctrl;
  sample_t                    operand;
  coef_t                      coef;
  logic signed [OUT_BITS-1:0] result;
  logic                       last_tap;

  assign last_tap = (tap_r == TAP_W'(TAP_COUNT - 1));
  assign operand  = (tap_r == '0) ? x_r : hist_r[0];
  assign coef     = tap_coef(IDX_W'(tap_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_rdy    = 1'b0;
    load_out  = 1'b0;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          ctrl.clr  = 1'b1;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        ctrl.mul_en = 1'b1;
        if (last_tap) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      x_r <= in_ch.sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          tap_r <= '0;
        end
        S_MAC: begin
          tap_r <= tap_r + TAP_W'(1);
          // rotate: after HIST_LEN steps the line is back in order
          if (tap_r != '0) begin
            for (int i = 0; i < HIST_LEN - 1; i++) begin
              hist_r[i] <= hist_r[i+1];
            end
            hist_r[HIST_LEN-1] <= hist_r[0];
          end
        end
        S_DRAIN: begin
          for (int i = 1; i < HIST_LEN; i++) begin
            hist_r[i] <= hist_r[i-1];
          end
          hist_r[0] <= x_r;
        end
        default: begin
        end
      endcase
    end
  end

  ffr_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .coef    (coef),
    .operand (operand),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

endmodule
`default_nettype wire

/* hw/rtl/ffr_checker.sv */
// Port-level checks on the FIR reverb filter core, bound into the core module.
// Depends on ffr_pkg and fixed_fir_reverb_filter_core.
`timescale 1ns / 1ps
`default_nettype none
module ffr_checker import ffr_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [OUT_BITS-1:0] out_data
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input ready right after a transfer");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_xfer))
    else $error("result appeared one cycle after input");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the handshake state");

endmodule

bind fixed_fir_reverb_filter_core ffr_checker u_ffr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.sample_out)
);
`default_nettype wire

/* dv/tb_fixed_fir_reverb_filter_core.sv */
// Testbench for fixed_fir_reverb_filter_core: drives input samples, predicts each filtered
// sample with a 64-tap FIR model in a scoreboard class and checks every output transfer.
// Depends on ffr_pkg, ffr_stream_if and the core RTL.
`timescale 1ns / 1ps
module tb_fixed_fir_reverb_filter_core;
  import ffr_pkg::*;

  localparam int RANDOM_SAMPLES = 1400;
  localparam int QUIET_TAIL     = 150;
  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 80;

  class fir_scoreboard;
    sample_t history[HIST_LEN];
    sample_t filtered_q[$];
    int      mismatches;
    int      checked;
    int      sat_high;
    int      sat_low;

    function new();
      foreach (history[i]) history[i] = '0;
      mismatches = 0;
      checked    = 0;
      sat_high   = 0;
      sat_low    = 0;
    endfunction

    // Q.30 sum of products, round half up to Q1.15, saturate
    function void note_sample(sample_t x);
      longint acc;
      longint q;
      acc = longint'(COEF_ROM[0]) * longint'(x);
      for (int k = 1; k < TAP_COUNT; k++) begin
        if (k < ROM_LEN) acc += longint'(COEF_ROM[k]) * longint'(history[k-1]);
      end
      for (int k = HIST_LEN - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = x;
      q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (q > 32767) begin
        q = 32767;
        sat_high++;
      end
      if (q < -32768) begin
        q = -32768;
        sat_low++;
      end
      filtered_q.push_back(sample_t'(q));
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_sample(logic signed [OUT_BITS-1:0] got);
      sample_t want;
      if (filtered_q.size() == 0) begin
        report($sformatf("output transfer %0d with nothing pending", got));
      end else begin
        want = filtered_q.pop_front();
        checked++;
        if (got !== want) report($sformatf("sample_out %0d, want %0d", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  ffr_in_if  in_ch ();
  ffr_out_if out_ch ();

  fixed_fir_reverb_filter_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fir_scoreboard sb;
  bit            in_gaps_on;
  bit            out_gaps_on;
  bit            hold_req;
  int            idle_cycles;
  int            sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_sample(sample_t x);
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.sample_in = x;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(x);
    sent++;
    @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (out_gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      if (out_ch.valid) sb.check_sample(out_ch.sample_out);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $realtime, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int      directed_seq[20] = '{-8192, 12288, 0, -32768, 32767, -1, 1, 21845, -21846,
                                  32767, 32767, 32767, 32767, -32768, -32768, -32768,
                                  -32768, 16384, -16384, 0};
    int      rnd_count;
    int      mode;
    int      seg_len;
    int      amp;
    int      v;
    bit      flip;
    bit      hold_done;
    sample_t x;

    sb              = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_gaps_on      = 1'b1;
    out_gaps_on     = 1'b1;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    idle_cycles     = 0;
    sent            = 0;
    rnd_count       = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // start-up from cleared history: ties at -127.5 and +519.5, then extremes
    foreach (directed_seq[i]) send_sample(sample_t'(directed_seq[i]));

    while (rnd_count < RANDOM_SAMPLES) begin
      mode    = $urandom_range(0, 9);
      seg_len = $urandom_range(16, 64);
      flip    = $urandom_range(0, 1);
      amp     = $urandom_range(20000, 32767);
      if (mode <= 3) begin
        // oldest first, each sample matched to the sign of its tap: drives saturation
        for (int j = 0; j < TAP_COUNT; j++) begin
          v = (COEF_ROM[TAP_COUNT-1-j] >= 0) ? amp : -amp - int'($urandom_range(0, 1));
          if (flip) v = (v > 0) ? -v - 1 : -v - 1;
          send_sample(sample_t'(v));
          rnd_count++;
        end
      end else begin
        for (int j = 0; j < seg_len; j++) begin
          case (mode)
            4, 5:    x = sample_t'($urandom);
            6:       x = sample_t'(int'($urandom_range(0, 511)) - 256);
            7:       x = flip ? sample_t'(-32768) : sample_t'(32767);
            8:       x = ($urandom_range(0, 7) == 0) ? sample_t'($urandom) : '0;
            default: x = sample_t'(int'($urandom_range(0, 65535)) - 32768);
          endcase
          send_sample(x);
          rnd_count++;
        end
      end
      if (!hold_done && rnd_count >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (rnd_count >= RANDOM_SAMPLES - QUIET_TAIL) begin
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
      end
    end
    in_ch.valid = 1'b0;

    while (sb.filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d input samples and %0d checked results, %0d mismatches.",
             sent, sb.checked, sb.mismatches);
    $display("Saturated results: %0d at the top, %0d at the bottom.",
             sb.sat_high, sb.sat_low);
    if (sb.mismatches == 0 && sb.filtered_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ffr_pkg.sv
hw/rtl/ffr_stream_if.sv
hw/rtl/ffr_mac.sv
hw/rtl/fixed_fir_reverb_filter_core.sv
hw/rtl/ffr_checker.sv
dv/tb_fixed_fir_reverb_filter_core.sv
